// ----- src/hyperspherical_coordinate_converter_unit_macros.svh -----
`ifndef HYPERSPHERICAL_COORDINATE_CONVERTER_UNIT_MACROS_SVH
`define HYPERSPHERICAL_COORDINATE_CONVERTER_UNIT_MACROS_SVH

// checked while out of reset
`define HCC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define HCC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/hcc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package hcc_pkg;

  localparam int MAX_DIMS_DEF    = 16;
  localparam int VALUE_WIDTH_DEF = 24;
  localparam int DIMS_W          = 5;
  localparam int QUEUE_DEPTH     = 4;
  localparam int CORDIC_STEPS    = 30;
  localparam int STEP_W          = 5;
  localparam int ANG_W           = 36;
  localparam int TRIG_W          = 33;

  localparam logic [DIMS_W-1:0] DIMS_RESET = DIMS_W'(2);
  localparam logic              ADDR_DIMS  = 1'b0;

  localparam logic DIR_TO_POLAR = 1'b0;
  localparam logic DIR_TO_CART  = 1'b1;

  localparam logic signed [ANG_W-1:0]  PI_Q30       = 36'sd3373259426;
  localparam logic signed [ANG_W-1:0]  HALF_PI_Q30  = 36'sd1686629713;
  localparam logic signed [ANG_W-1:0]  TWO_PI_Q30   = 36'sd6746518852;
  localparam logic signed [TRIG_W-1:0] GAIN_INV_Q30 = 33'sd652032874;

  typedef struct packed {
    logic              dir;
    logic              last;
    logic [DIMS_W-1:0] n;
    logic [DIMS_W-1:0] pos;
  } hcc_ctrl_t;

  function automatic logic [ANG_W-1:0] atan_q30(input logic [STEP_W-1:0] i);
    logic [ANG_W-1:0] r;
    unique case (i)
      5'd0:  r = 36'd843314857;
      5'd1:  r = 36'd497837830;
      5'd2:  r = 36'd263043837;
      5'd3:  r = 36'd133525159;
      5'd4:  r = 36'd67021687;
      5'd5:  r = 36'd33543516;
      5'd6:  r = 36'd16775851;
      5'd7:  r = 36'd8388437;
      5'd8:  r = 36'd4194283;
      5'd9:  r = 36'd2097149;
      5'd10: r = 36'd1048576;
      5'd11: r = 36'd524288;
      5'd12: r = 36'd262144;
      5'd13: r = 36'd131072;
      5'd14: r = 36'd65536;
      5'd15: r = 36'd32768;
      5'd16: r = 36'd16384;
      5'd17: r = 36'd8192;
      5'd18: r = 36'd4096;
      5'd19: r = 36'd2048;
      5'd20: r = 36'd1024;
      5'd21: r = 36'd512;
      5'd22: r = 36'd256;
      5'd23: r = 36'd128;
      5'd24: r = 36'd64;
      5'd25: r = 36'd32;
      5'd26: r = 36'd16;
      5'd27: r = 36'd8;
      5'd28: r = 36'd4;
      5'd29: r = 36'd2;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- src/hcc_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "hyperspherical_coordinate_converter_unit_macros.svh"

module hcc_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         nonempty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full     = (count == CNT_W'(DEPTH));
  assign nonempty = (count != '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  `HCC_ASSERT(a_count_bound, count <= CNT_W'(DEPTH), "queue count beyond depth")
  `HCC_ASSERT(a_count_grow, (do_push && !do_pop) |=> count == $past(count) + 1'b1,
              "queue count did not follow a push")

endmodule

`default_nettype wire

// ----- src/hcc_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module hcc_front #(
  parameter int MAX_DIMS    = 16,
  parameter int VALUE_WIDTH = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [VALUE_WIDTH-1:0]        s_value,
  input  logic                          s_tuser,
  output logic                          q_push,
  output logic [VALUE_WIDTH-1:0]        q_value,
  output hcc_pkg::hcc_ctrl_t            q_ctrl,
  input  logic                          q_full
);
  import hcc_pkg::*;

  logic [DIMS_W-1:0] dims;
  logic [DIMS_W-1:0] load_count;
  logic              dir_latch;
  logic [DIMS_W-1:0] n_eff, pos;
  logic              dir_now, is_last;

  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == ADDR_DIMS) ? 32'(dims) : '0;
  assign s_tready = !q_full;
  assign q_push   = s_tvalid && s_tready;

  always_comb begin
    if (dims == '0) begin
      n_eff = DIMS_W'(1);
    end else if (32'(dims) > MAX_DIMS) begin
      n_eff = DIMS_W'(MAX_DIMS);
    end else begin
      n_eff = dims;
    end
    // a shortened vector lands its item on the last slot
    pos     = (load_count >= n_eff) ? n_eff - 1'b1 : load_count;
    is_last = (pos + 1'b1 == n_eff);
    dir_now = (load_count == '0) ? s_tuser : dir_latch;
  end

  assign q_value     = s_value;
  assign q_ctrl.dir  = dir_now;
  assign q_ctrl.last = is_last;
  assign q_ctrl.n    = n_eff;
  assign q_ctrl.pos  = pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      dims       <= DIMS_RESET;
      load_count <= '0;
      dir_latch  <= DIR_TO_POLAR;
    end else begin
      if (psel && penable && pwrite && pready && paddr[2] == ADDR_DIMS) begin
        dims <= pwdata[DIMS_W-1:0];
      end
      if (q_push) begin
        dir_latch  <= dir_now;
        load_count <= is_last ? '0 : pos + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/hcc_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "hyperspherical_coordinate_converter_unit_macros.svh"

module hcc_back #(
  parameter int MAX_DIMS    = 16,
  parameter int VALUE_WIDTH = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  output logic                   q_pop,
  input  logic [VALUE_WIDTH-1:0] q_value,
  input  hcc_pkg::hcc_ctrl_t     q_ctrl,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [VALUE_WIDTH-1:0] m_value,
  output logic                   m_last
);
  import hcc_pkg::*;

  localparam int VW        = VALUE_WIDTH;
  localparam int IDX_W     = $clog2(MAX_DIMS);
  localparam int YW        = VW + 3;
  localparam int CW        = VW + 22;
  localparam int PW        = VW + 2;
  localparam int RW        = VW + 8;
  localparam int MW        = VW + 14;
  localparam int RED_STEPS = VW - 16;
  localparam int RK_W      = $clog2(RED_STEPS + 2);
  localparam int CMP_W     = VW + 18;
  localparam int PRD_W     = PW + TRIG_W;

  localparam logic signed [RW-1:0] RES_MAX =
    $signed({{(RW - VW + 1){1'b0}}, {(VW - 1){1'b1}}});
  localparam logic signed [RW-1:0] RES_MIN =
    $signed({{(RW - VW + 1){1'b1}}, {(VW - 1){1'b0}}});
  localparam logic signed [PRD_W-1:0] RND_HALF =
    $signed({{(PRD_W - 30){1'b0}}, 1'b1, 29'b0});
  localparam logic signed [ANG_W-1:0] Q16_HALF = 36'sd8192;

  typedef enum logic [4:0] {
    S_LOAD, S_PASS_RD, S_PASS, S_EMIT,
    S_T_RD, S_T_SQ, S_T_ACC, S_T_DONE, S_ZERO,
    S_SQRT, S_RAD_OUT, S_A_CHK, S_A_RD, S_A_GO,
    S_L_RD0, S_L_RD1, S_L_WAIT, S_L_GO,
    S_ATAN_INIT, S_CORDIC, S_ATAN_FIN, S_ANG_OUT,
    S_R_RD, S_R_GO, S_C_CHK, S_C_RD, S_C_GO, S_RED, S_FOLD,
    S_SC_FIN, S_MUL_C, S_MUL_S
  } state_t;

  state_t state, ret_st, sq_ret, mul_ret;

  logic signed [VW-1:0] store [MAX_DIMS];
  logic [63:0]          tail_mem [MAX_DIMS];
  logic signed [VW-1:0] st_rdata;
  logic [63:0]          tl_rdata;
  logic [IDX_W-1:0]     st_raddr, tl_raddr;
  logic                 tl_we;

  logic [DIMS_W-1:0]     n, j, k, rd_idx;
  logic                  dir;
  logic [63:0]           acc, acc_next, prev_tail;
  logic [64:0]           acc_sum;
  logic [2*VW-1:0]       sqv;
  logic [63:0]           sq_v, sq_r, sq_b, sq_rb;
  logic signed [VW-1:0]  xprev, xl;
  logic [VW:0]           xprev_abs, xl_abs, rd_abs;
  logic                  is_last_ang, atx_neg, neg_flag, rot;
  logic signed [CW-1:0]  cx, cy, shx, shy;
  logic signed [ANG_W-1:0] z, at, a0, a1, a2, ang_fin, ang_q;
  logic                  fneg;
  logic [STEP_W-1:0]     it;
  logic [MW-1:0]         mag;
  logic [RK_W-1:0]       rk;
  logic [CMP_W-1:0]      thr;
  logic signed [TRIG_W-1:0] sn;
  logic signed [PW-1:0]  p, p_rnd;
  logic signed [PRD_W-1:0] prod, rnd_full;
  logic signed [RW-1:0]  res, res_sat;
  logic                  res_last, out_free, mul_sin;
  logic [YW-1:0]         yv;

  function automatic logic [VW:0] abs_v(input logic signed [VW-1:0] v);
    logic signed [VW:0] e;
    e = {v[VW-1], v};
    return (e < 0) ? $unsigned(-e) : $unsigned(e);
  endfunction

  assign st_raddr = IDX_W'(rd_idx);
  assign tl_raddr = IDX_W'(j);
  assign q_pop    = (state == S_LOAD) && q_valid;
  assign out_free = !m_tvalid || m_tready;
  assign tl_we    = (state == S_T_ACC);

  always_ff @(posedge clk) begin
    if (q_pop) begin
      store[IDX_W'(q_ctrl.pos)] <= $signed(q_value);
    end
    st_rdata <= store[st_raddr];
  end

  always_ff @(posedge clk) begin
    if (tl_we) begin
      tail_mem[IDX_W'(k)] <= acc_next;
    end
    tl_rdata <= tail_mem[tl_raddr];
  end

  always_comb begin
    acc_sum   = {1'b0, acc} + 65'(sqv);
    acc_next  = acc_sum[64] ? '1 : acc_sum[63:0];
    sq_rb     = sq_r + sq_b;
    shx       = cx >>> it;
    shy       = cy >>> it;
    at        = $signed(atan_q30(it));
    xprev_abs = abs_v(xprev);
    xl_abs    = abs_v(xl);
    rd_abs    = abs_v(st_rdata);
    yv        = is_last_ang ? YW'(xl_abs) : YW'(sq_r);
    thr       = CMP_W'($unsigned(TWO_PI_Q30)) << rk;
    // reduce to one turn, then fold into the right half plane
    a0 = neg_flag ? -$signed(ANG_W'(mag)) : $signed(ANG_W'(mag));
    if (a0 > PI_Q30) begin
      a1 = a0 - TWO_PI_Q30;
    end else if (a0 < -PI_Q30) begin
      a1 = a0 + TWO_PI_Q30;
    end else begin
      a1 = a0;
    end
    if (a1 > HALF_PI_Q30) begin
      a2 = a1 - PI_Q30;
      fneg = 1'b1;
    end else if (a1 < -HALF_PI_Q30) begin
      a2 = a1 + PI_Q30;
      fneg = 1'b1;
    end else begin
      a2 = a1;
      fneg = 1'b0;
    end
    ang_fin  = (is_last_ang && xl[VW-1]) ? TWO_PI_Q30 - z : z;
    ang_q    = (ang_fin + Q16_HALF) >>> 14;
    rnd_full = (prod + RND_HALF) >>> 30;
    p_rnd    = rnd_full[PW-1:0];
    if (res > RES_MAX) begin
      res_sat = RES_MAX;
    end else if (res < RES_MIN) begin
      res_sat = RES_MIN;
    end else begin
      res_sat = res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_LOAD;
      m_tvalid    <= 1'b0;
      ret_st      <= S_LOAD;
      sq_ret      <= S_LOAD;
      mul_ret     <= S_LOAD;
      is_last_ang <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_EMIT) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_LOAD: begin
          if (q_valid && q_ctrl.last) begin
            n           <= q_ctrl.n;
            dir         <= q_ctrl.dir;
            is_last_ang <= 1'b0;
            if (q_ctrl.n == DIMS_W'(1)) begin
              rd_idx <= '0;
              state  <= S_PASS_RD;
            end else if (q_ctrl.dir == DIR_TO_POLAR) begin
              k      <= q_ctrl.n - 1'b1;
              rd_idx <= q_ctrl.n - 1'b1;
              acc    <= '0;
              state  <= S_T_RD;
            end else begin
              rd_idx <= '0;
              state  <= S_R_RD;
            end
          end
        end
        S_PASS_RD: state <= S_PASS;
        S_PASS: begin
          res      <= RW'(st_rdata);
          res_last <= 1'b1;
          ret_st   <= S_LOAD;
          state    <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_value  <= res_sat[VW-1:0];
            m_last   <= res_last;
            state    <= ret_st;
          end
        end
        // tail sums of squares, last component first
        S_T_RD: state <= S_T_SQ;
        S_T_SQ: begin
          sqv   <= $unsigned((2*VW)'(st_rdata) * (2*VW)'(st_rdata));
          state <= S_T_ACC;
        end
        S_T_ACC: begin
          acc <= acc_next;
          if (k == '0) begin
            state <= S_T_DONE;
          end else begin
            k      <= k - 1'b1;
            rd_idx <= k - 1'b1;
            state  <= S_T_RD;
          end
        end
        S_T_DONE: begin
          if (acc == '0) begin
            j     <= '0;
            state <= S_ZERO;
          end else begin
            prev_tail <= acc;
            sq_v      <= acc;
            sq_r      <= '0;
            sq_b      <= 64'h4000_0000_0000_0000;
            sq_ret    <= S_RAD_OUT;
            state     <= S_SQRT;
          end
        end
        S_ZERO: begin
          res      <= '0;
          res_last <= (j == n - 1'b1);
          ret_st   <= (j == n - 1'b1) ? S_LOAD : S_ZERO;
          j        <= j + 1'b1;
          state    <= S_EMIT;
        end
        S_SQRT: begin
          if (sq_v >= sq_rb) begin
            sq_v <= sq_v - sq_rb;
            sq_r <= (sq_r >> 1) + sq_b;
          end else begin
            sq_r <= sq_r >> 1;
          end
          sq_b <= sq_b >> 2;
          if (sq_b == 64'd1) begin
            state <= sq_ret;
          end
        end
        S_RAD_OUT: begin
          res      <= $signed(RW'(sq_r));
          res_last <= 1'b0;
          ret_st   <= S_A_CHK;
          j        <= DIMS_W'(1);
          state    <= S_EMIT;
        end
        S_A_CHK: begin
          if (j == n - 1'b1) begin
            rd_idx <= n - 2'd2;
            state  <= S_L_RD0;
          end else begin
            rd_idx <= j - 1'b1;
            state  <= S_A_RD;
          end
        end
        S_A_RD: state <= S_A_GO;
        S_A_GO: begin
          xprev     <= st_rdata;
          prev_tail <= tl_rdata;
          j         <= j + 1'b1;
          if (prev_tail == '0) begin
            res      <= '0;
            res_last <= 1'b0;
            ret_st   <= S_A_CHK;
            state    <= S_EMIT;
          end else begin
            sq_v   <= tl_rdata;
            sq_r   <= '0;
            sq_b   <= 64'h4000_0000_0000_0000;
            sq_ret <= S_ATAN_INIT;
            state  <= S_SQRT;
          end
        end
        S_L_RD0: state <= S_L_RD1;
        S_L_RD1: begin
          xprev  <= st_rdata;
          rd_idx <= n - 1'b1;
          state  <= S_L_WAIT;
        end
        S_L_WAIT: state <= S_L_GO;
        S_L_GO: begin
          xl          <= st_rdata;
          is_last_ang <= 1'b1;
          state       <= S_ATAN_INIT;
        end
        S_ATAN_INIT: begin
          atx_neg <= xprev[VW-1];
          if (yv == '0) begin
            z     <= xprev[VW-1] ? PI_Q30 : '0;
            state <= S_ANG_OUT;
          end else if (xprev == '0) begin
            z     <= HALF_PI_Q30;
            state <= S_ANG_OUT;
          end else begin
            cx    <= $signed(CW'(xprev_abs) << 16);
            cy    <= $signed(CW'(yv) << 16);
            z     <= '0;
            it    <= '0;
            rot   <= 1'b0;
            state <= S_CORDIC;
          end
        end
        S_CORDIC: begin
          if (!rot) begin
            if (cy > 0) begin
              cx <= cx + shy;
              cy <= cy - shx;
              z  <= z + at;
            end else begin
              cx <= cx - shy;
              cy <= cy + shx;
              z  <= z - at;
            end
          end else begin
            if (z >= 0) begin
              cx <= cx - shy;
              cy <= cy + shx;
              z  <= z - at;
            end else begin
              cx <= cx + shy;
              cy <= cy - shx;
              z  <= z + at;
            end
          end
          it <= it + 1'b1;
          if (it == STEP_W'(CORDIC_STEPS - 1)) begin
            state <= rot ? S_SC_FIN : S_ATAN_FIN;
          end
        end
        S_ATAN_FIN: begin
          z     <= atx_neg ? PI_Q30 - z : z;
          state <= S_ANG_OUT;
        end
        S_ANG_OUT: begin
          res      <= RW'(ang_q);
          res_last <= is_last_ang;
          ret_st   <= is_last_ang ? S_LOAD : S_A_CHK;
          state    <= S_EMIT;
        end
        // polar to cartesian: running product of sines
        S_R_RD: state <= S_R_GO;
        S_R_GO: begin
          p     <= PW'(st_rdata);
          j     <= DIMS_W'(1);
          state <= S_C_CHK;
        end
        S_C_CHK: begin
          if (j == n) begin
            res      <= RW'(p);
            res_last <= 1'b1;
            ret_st   <= S_LOAD;
            state    <= S_EMIT;
          end else begin
            rd_idx <= j;
            state  <= S_C_RD;
          end
        end
        S_C_RD: state <= S_C_GO;
        S_C_GO: begin
          mag      <= MW'(rd_abs) << 14;
          neg_flag <= st_rdata[VW-1];
          rk       <= RK_W'(RED_STEPS);
          state    <= S_RED;
        end
        S_RED: begin
          if (CMP_W'(mag) >= thr) begin
            mag <= mag - MW'(thr);
          end
          if (rk == '0) begin
            state <= S_FOLD;
          end else begin
            rk <= rk - 1'b1;
          end
        end
        S_FOLD: begin
          cx       <= CW'(GAIN_INV_Q30);
          cy       <= '0;
          z        <= a2;
          neg_flag <= fneg;
          it       <= '0;
          rot      <= 1'b1;
          state    <= S_CORDIC;
        end
        S_SC_FIN: begin
          sn      <= neg_flag ? -TRIG_W'(cy) : TRIG_W'(cy);
          prod    <= p * (neg_flag ? -TRIG_W'(cx) : TRIG_W'(cx));
          mul_sin <= 1'b0;
          mul_ret <= S_MUL_S;
          state   <= S_MUL_C;
        end
        S_MUL_C: begin
          if (!mul_sin) begin
            res      <= RW'(p_rnd);
            res_last <= 1'b0;
            ret_st   <= mul_ret;
            state    <= S_EMIT;
          end else begin
            p     <= p_rnd;
            j     <= j + 1'b1;
            state <= S_C_CHK;
          end
        end
        S_MUL_S: begin
          prod    <= p * sn;
          mul_sin <= 1'b1;
          state   <= S_MUL_C;
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  `HCC_ASSERT(a_emit_src, $rose(m_tvalid) |-> $past(state == S_EMIT),
              "result loaded outside the emit step")
  `HCC_ASSERT(a_tail_mono, (state == S_T_ACC) |-> acc_next >= acc,
              "tail sum decreased")
  `HCC_ASSERT(a_load_cart, (state == S_C_CHK) |-> dir == DIR_TO_CART,
              "cartesian sequence on a polar vector")

endmodule

`default_nettype wire

// ----- src/hyperspherical_coordinate_converter_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Hyperspherical coordinate converter.
// Input stream: s_tdata carries one vector component (signed Q7.16), s_tuser
// the direction (0 cartesian to polar, 1 polar to cartesian), read on the
// first component of each vector. dims components make one vector.
// Output stream: dims converted components per vector, m_tlast on the final.
// Configuration: APB register dims at address 0 (reset value 2).
// Input items enter a four-entry queue, so the loader takes a new item every
// cycle until the queue fills; a vector is converted once its last item is
// out of the queue. Conversion runs on the shared 30-step CORDIC and the
// 32-step square root: cartesian to polar forms the tail sums, then the
// radius, each inner angle and the last angle; polar to cartesian reduces
// each angle and forms the components in turn; a 1-dimensional vector
// passes through unchanged. A stalled m_tready holds the output register
// and the conversion sequence; the queue keeps taking input until full.
// Reset clears the load position, direction, queue and output valid; no
// clearing pass is needed.
module hyperspherical_coordinate_converter_unit #(
  parameter int MAX_DIMS    = hcc_pkg::MAX_DIMS_DEF,
  parameter int VALUE_WIDTH = hcc_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [2:0]                           paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [((VALUE_WIDTH+7)/8)*8-1:0]     s_tdata,  // value
  input  logic                                 s_tuser,  // op
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [((VALUE_WIDTH+7)/8)*8-1:0]     m_tdata,  // value_res
  output logic                                 m_tlast
);
  import hcc_pkg::*;

  localparam int DATA_W = ((VALUE_WIDTH + 7) / 8) * 8;
  localparam int Q_W    = VALUE_WIDTH + $bits(hcc_ctrl_t);

  logic                   q_push, q_full, q_pop, q_nonempty;
  logic [VALUE_WIDTH-1:0] f_value, b_value, m_value;
  hcc_ctrl_t              f_ctrl, b_ctrl;
  logic [Q_W-1:0]         q_in, q_out;

  hcc_front #(.MAX_DIMS(MAX_DIMS), .VALUE_WIDTH(VALUE_WIDTH)) u_front (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_value(s_tdata[VALUE_WIDTH-1:0]), .s_tuser(s_tuser),
    .q_push(q_push), .q_value(f_value), .q_ctrl(f_ctrl), .q_full(q_full)
  );

  assign q_in = {f_value, f_ctrl};

  hcc_fifo #(.W(Q_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst(rst),
    .push(q_push), .push_data(q_in), .full(q_full),
    .pop(q_pop), .pop_data(q_out), .nonempty(q_nonempty)
  );

  assign b_value = q_out[Q_W-1 -: VALUE_WIDTH];
  assign b_ctrl  = q_out[$bits(hcc_ctrl_t)-1:0];

  hcc_back #(.MAX_DIMS(MAX_DIMS), .VALUE_WIDTH(VALUE_WIDTH)) u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_nonempty), .q_pop(q_pop), .q_value(b_value), .q_ctrl(b_ctrl),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_value(m_value), .m_last(m_tlast)
  );

  assign m_tdata = DATA_W'(m_value);

endmodule

`default_nettype wire

// ----- verif/hyperspherical_coordinate_converter_unit_checker.sv -----
`timescale 1ns / 1ps

module hyperspherical_coordinate_converter_unit_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [23:0] s_tdata,   // value
  input  logic        s_tuser,   // op
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,   // value_res
  input  logic        m_tlast,
  output int          fail_count,
  output int          pending,
  output int          result_count,
  output int          vector_count
);

  localparam int NMAX = 16;
  localparam int STEPS = 30;
  localparam longint PI_Q = 64'sd3373259426;
  localparam longint HALF_PI_Q = 64'sd1686629713;
  localparam longint TWO_PI_Q = 64'sd6746518852;
  localparam longint GAIN_INV_Q = 64'sd652032874;
  localparam longint VAL_MAX = 64'sd8388607;
  localparam longint VAL_MIN = -64'sd8388608;

  localparam longint ATAN_STEP [STEPS] = '{
    843314857, 497837830, 263043837, 133525159, 67021687,
    33543516, 16775851, 8388437, 4194283, 2097149,
    1048576, 524288, 262144, 131072, 65536,
    32768, 16384, 8192, 4096, 2048,
    1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};

  typedef struct {
    logic signed [23:0] value;
    logic               last;
  } conv_result_t;

  conv_result_t converted_q[$];

  longint      comp_store [NMAX];
  longint      conv_out [NMAX];
  int          load_pos;
  logic        direction;
  logic [4:0]  dims_reg;

  function automatic longint clamp_val(longint v);
    return v > VAL_MAX ? VAL_MAX : (v < VAL_MIN ? VAL_MIN : v);
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  function automatic longint round_q16(longint a);
    return (a + 8192) >>> 14;
  endfunction

  // angle of (x, y) with y >= 0, Q.30 in [0, pi]
  function automatic longint arctan_q30(longint y, longint x);
    longint cx, cy, z, nx;
    z = 0;
    if (y == 0) return x < 0 ? PI_Q : 0;
    if (x == 0) return HALF_PI_Q;
    cx = (x < 0 ? -x : x) * 65536;
    cy = y * 65536;
    for (int i = 0; i < STEPS; i++) begin
      if (cy > 0) begin
        nx = cx + (cy >>> i);
        cy = cy - (cx >>> i);
        z = z + ATAN_STEP[i];
      end else begin
        nx = cx - (cy >>> i);
        cy = cy + (cx >>> i);
        z = z - ATAN_STEP[i];
      end
      cx = nx;
    end
    return x < 0 ? PI_Q - z : z;
  endfunction

  function automatic void sin_cos(input longint ang, output longint s, output longint c);
    longint a, x, y, nx;
    bit neg;
    a = (ang * 16384) % TWO_PI_Q;
    x = GAIN_INV_Q;
    y = 0;
    neg = 0;
    if (a > PI_Q) a = a - TWO_PI_Q;
    else if (a < -PI_Q) a = a + TWO_PI_Q;
    if (a > HALF_PI_Q) begin
      a = a - PI_Q;
      neg = 1;
    end else if (a < -HALF_PI_Q) begin
      a = a + PI_Q;
      neg = 1;
    end
    for (int i = 0; i < STEPS; i++) begin
      if (a >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        a = a - ATAN_STEP[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        a = a + ATAN_STEP[i];
      end
      x = nx;
    end
    s = neg ? -y : y;
    c = neg ? -x : x;
  endfunction

  function automatic longint scale_q30(longint v, longint f);
    return (v * f + (64'sd1 << 29)) >>> 30;
  endfunction

  task automatic cart_to_polar(int n);
    longint unsigned tail [NMAX+1];
    longint a, xl;
    tail[n] = 0;
    for (int k = n - 1; k >= 0; k--)
      tail[k] = tail[k+1] + longint'(comp_store[k] * comp_store[k]);
    for (int k = 0; k < n; k++) conv_out[k] = 0;
    if (tail[0] != 0) begin
      conv_out[0] = clamp_val(int_sqrt(tail[0]));
      for (int j = 1; j + 1 < n; j++)
        if (tail[j-1] != 0)
          conv_out[j] = clamp_val(round_q16(arctan_q30(int_sqrt(tail[j]), comp_store[j-1])));
      xl = comp_store[n-1];
      a = arctan_q30(xl < 0 ? -xl : xl, comp_store[n-2]);
      // reflect into the lower half plane
      if (xl < 0) a = TWO_PI_Q - a;
      conv_out[n-1] = clamp_val(round_q16(a));
    end
  endtask

  task automatic polar_to_cart(int n);
    longint sn [NMAX];
    longint cs [NMAX];
    longint v;
    for (int j = 1; j < n; j++) sin_cos(comp_store[j], sn[j], cs[j]);
    for (int i = 1; i < n; i++) begin
      v = comp_store[0];
      for (int j = 1; j < i; j++) v = scale_q30(v, sn[j]);
      v = scale_q30(v, cs[i]);
      conv_out[i-1] = clamp_val(v);
    end
    v = comp_store[0];
    for (int j = 1; j < n; j++) v = scale_q30(v, sn[j]);
    conv_out[n-1] = clamp_val(v);
  endtask

  task automatic absorb_component(logic op, logic signed [23:0] val);
    int n, pos;
    conv_result_t r;
    n = dims_reg == 0 ? 1 : (dims_reg > NMAX ? NMAX : int'(dims_reg));
    if (load_pos == 0) direction = op;
    // a lowered dims completes the vector at its last slot
    pos = load_pos >= n ? n - 1 : load_pos;
    comp_store[pos] = longint'(val);
    load_pos = pos + 1;
    if (load_pos >= n) begin
      load_pos = 0;
      vector_count++;
      if (n == 1) conv_out[0] = comp_store[0];
      else if (direction == hcc_pkg::DIR_TO_POLAR) cart_to_polar(n);
      else polar_to_cart(n);
      for (int k = 0; k < n; k++) begin
        r.value = conv_out[k][23:0];
        r.last = (k == n - 1);
        converted_q.insert(converted_q.size(), r);
      end
    end
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
    result_count = 0;
    vector_count = 0;
    load_pos = 0;
    direction = hcc_pkg::DIR_TO_POLAR;
    dims_reg = hcc_pkg::DIMS_RESET;
  end

  always @(posedge clk) begin
    conv_result_t want;
    if (!rst) begin
      if (psel && penable && pwrite && pready && paddr == 3'(hcc_pkg::ADDR_DIMS) << 2)
        dims_reg = pwdata[4:0];
      if (s_tvalid && s_tready) absorb_component(s_tuser, s_tdata);
      if (m_tvalid && m_tready) begin
        result_count++;
        if (converted_q.size() == 0) begin
          $error("unexpected result value_res=%0d last=%0b", $signed(m_tdata), m_tlast);
          fail_count++;
        end else begin
          want = converted_q.pop_front();
          if (m_tdata !== want.value) begin
            $error("value_res: expected %0d, got %0d", want.value, $signed(m_tdata));
            fail_count++;
          end
          if (m_tlast !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, m_tlast);
            fail_count++;
          end
        end
      end
    end
    pending <= converted_q.size();
  end

endmodule

// ----- verif/hyperspherical_coordinate_converter_unit_tb.sv -----
`timescale 1ns / 1ps

module hyperspherical_coordinate_converter_unit_tb;

  localparam int CYCLE_LIMIT = 1500000;
  localparam logic [23:0] V_MAX = 24'h7FFFFF;
  localparam logic [23:0] V_MIN = 24'h800000;

  logic        clk;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // value
  logic        s_tuser = 1'b0; // op
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;        // value_res
  logic        m_tlast;

  int fail_count, pending, result_count, vector_count;
  int items_sent = 0;
  int cycles = 0;
  bit quiet = 0;
  bit long_hold = 0;

  hyperspherical_coordinate_converter_unit DUT (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  hyperspherical_coordinate_converter_unit_checker u_checker (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .fail_count(fail_count), .pending(pending),
    .result_count(result_count), .vector_count(vector_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    int g;
    @(negedge rst);
    forever begin
      if (long_hold) begin
        m_tready <= 1'b0;
        repeat (3000) @(posedge clk);
        long_hold = 0;
      end
      g = quiet ? 0 : $urandom_range(0, 5);
      if (g > 0) begin
        m_tready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  task automatic write_dims(logic [4:0] d);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'(hcc_pkg::ADDR_DIMS) << 2;
    pwdata <= {27'd0, d};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // hold off until every result is out, then let the input queue drain
  task automatic drain();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic send_item(logic op, logic [23:0] v);
    int g;
    g = (quiet || long_hold) ? 0 : $urandom_range(0, 5);
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= v;
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  task automatic end_burst();
    s_tvalid <= 1'b0;
  endtask

  function automatic logic [23:0] pick_value();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return V_MAX;
      2: return V_MIN;
      3: return 24'($signed($urandom_range(0, 2000)) - 1000);
      4: return 24'($signed($urandom_range(0, 917504)) - 458752);  // about +-7 rad
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic send_vectors(int n, int count);
    logic op;
    for (int v = 0; v < count; v++) begin
      op = $urandom_range(0, 1);
      for (int k = 0; k < n; k++)
        send_item(k == 0 ? op : logic'($urandom_range(0, 1)), pick_value());
    end
    end_burst();
  endtask

  initial begin
    logic [4:0] dims_plan [10] = '{16, 5, 3, 31, 1, 2, 8, 17, 4, 6};
    int n;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // two dimensions at reset: zero vector, saturated radius, angle of pi, reflection
    send_item(hcc_pkg::DIR_TO_POLAR, 24'd0);
    send_item(hcc_pkg::DIR_TO_CART, 24'd0);
    send_item(hcc_pkg::DIR_TO_POLAR, V_MAX);
    send_item(hcc_pkg::DIR_TO_POLAR, V_MIN);
    send_item(hcc_pkg::DIR_TO_POLAR, -24'sd5);
    send_item(hcc_pkg::DIR_TO_POLAR, 24'd0);
    send_item(hcc_pkg::DIR_TO_POLAR, 24'd3);
    send_item(hcc_pkg::DIR_TO_POLAR, -24'sd4);
    // polar with angles far outside one turn
    send_item(hcc_pkg::DIR_TO_CART, V_MAX);
    send_item(hcc_pkg::DIR_TO_CART, V_MIN);
    send_item(hcc_pkg::DIR_TO_CART, V_MIN);
    send_item(hcc_pkg::DIR_TO_CART, V_MAX);
    end_burst();
    drain();
    write_dims(5'd1);
    send_item(hcc_pkg::DIR_TO_POLAR, V_MAX);
    send_item(hcc_pkg::DIR_TO_CART, V_MIN);
    end_burst();
    drain();
    // a zero tail ahead of the last angle
    write_dims(5'd4);
    send_item(hcc_pkg::DIR_TO_POLAR, 24'd5);
    repeat (3) send_item(hcc_pkg::DIR_TO_POLAR, 24'd0);
    // lower dims with a partial vector loaded
    repeat (3) send_item(hcc_pkg::DIR_TO_CART, 24'h010000);
    end_burst();
    drain();
    write_dims(5'd2);
    send_item(hcc_pkg::DIR_TO_POLAR, 24'h020000);
    end_burst();
    drain();
    write_dims(5'd0);
    send_item(hcc_pkg::DIR_TO_CART, 24'h123456);
    end_burst();
    drain();

    // input backs up while results are held off
    write_dims(5'd1);
    long_hold = 1;
    send_vectors(1, 30);
    drain();

    for (int p = 0; items_sent < 220; p++) begin
      logic [4:0] d;
      d = p < 10 ? dims_plan[p] : 5'($urandom_range(1, 16));
      n = d == 0 ? 1 : (d > 16 ? 16 : int'(d));
      quiet = (p % 4 == 2);
      write_dims(d);
      send_vectors(n, n > 8 ? 1 : 24 / n);
      drain();
    end
    quiet = 0;

    drain();
    repeat (200) @(posedge clk);
    $display("sent %0d items in %0d vectors, checked %0d results, dims 0 through 31",
             items_sent, vector_count, result_count);
    $display("both directions, pass-through, zero tails, reflection, saturation, long stall");
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
